/* rtl/core/lcdseq_pkg.sv */
// types, constants and helper functions for the character lcd nibble sequencer
// no dependencies; imported by every module of the block
package lcdseq_pkg;

  // command word on the input channel
  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] row;
    logic [5:0] column;
    logic [7:0] value;
    logic [2:0] flag_select;
    logic       flag_value;
  } cmd_t;

  // result word on the output channel
  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic       strobe_res;
    logic [1:0] wait_code;
    logic       last;
  } res_t;

  // command opcodes
  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_RAW   = 3'd1,
    OP_CHAR  = 3'd2,
    OP_POS   = 3'd3,
    OP_NUM   = 3'd4,
    OP_CLEAR = 3'd5,
    OP_MODE  = 3'd6
  } op_t;

  // mode bit selectors
  typedef enum logic [2:0] {
    SEL_DISPLAY     = 3'd0,
    SEL_CURSOR      = 3'd1,
    SEL_BLINK       = 3'd2,
    SEL_DISP_SHIFT  = 3'd3,
    SEL_SHIFT_RIGHT = 3'd4,
    SEL_ENTRY_RIGHT = 3'd5,
    SEL_ENTRY_MOVE  = 3'd6
  } sel_t;

  // wait codes
  localparam logic [1:0] WAIT_NONE    = 2'd0;
  localparam logic [1:0] WAIT_SHORT   = 2'd1;
  localparam logic [1:0] WAIT_CLEAR   = 2'd2;
  localparam logic [1:0] WAIT_POWERUP = 2'd3;

  // register reset values and fixed command bytes
  localparam logic [7:0] ON_OFF_RESET = 8'h0C;
  localparam logic [7:0] SHIFT_RESET  = 8'h14;
  localparam logic [7:0] ENTRY_RESET  = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] POS_BASE_ODD  = 8'h80;
  localparam logic [7:0] POS_BASE_EVEN = 8'hC0;

  // job queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // init sequence length
  localparam int INIT_LEN = 12;
  localparam logic [3:0] INIT_LAST = 4'(INIT_LEN - 1);

  // one queued job: either the init sequence or up to four bytes
  typedef struct packed {
    logic            is_init;
    logic [1:0]      nbytes_m1;
    logic            rs0;
    logic [1:0]      wait0;
    logic [3:0][7:0] bytes;
  } job_t;

  // queue status towards the back end
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // init sequence, one result per step (last is set by the sequencer)
  function automatic res_t init_res(input logic [3:0] idx);
    res_t r;
    r = '0;
    r.strobe_res = 1'b1;
    case (idx)
      4'd0: begin
        r.strobe_res = 1'b0;
        r.wait_code  = WAIT_POWERUP;
      end
      4'd1:  begin r.nibble = 4'h3; r.wait_code = WAIT_SHORT; end
      4'd2:  begin r.nibble = 4'h2; r.wait_code = WAIT_NONE;  end
      4'd3:  begin r.nibble = 4'hC; r.wait_code = WAIT_SHORT; end
      4'd4:  begin r.nibble = 4'h2; r.wait_code = WAIT_NONE;  end
      4'd5:  begin r.nibble = 4'hC; r.wait_code = WAIT_SHORT; end
      4'd6:  begin r.nibble = 4'h0; r.wait_code = WAIT_NONE;  end
      4'd7:  begin r.nibble = 4'hC; r.wait_code = WAIT_SHORT; end
      4'd8:  begin r.nibble = 4'h0; r.wait_code = WAIT_NONE;  end
      4'd9:  begin r.nibble = 4'h1; r.wait_code = WAIT_CLEAR; end
      4'd10: begin r.nibble = 4'h0; r.wait_code = WAIT_NONE;  end
      4'd11: begin r.nibble = 4'h6; r.wait_code = WAIT_SHORT; end
      default: r = '0;
    endcase
    return r;
  endfunction

  // 8-bit binary to three bcd digits, shift-and-add-three
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [11:0] bcd;
    bcd = '0;
    for (int i = 7; i >= 0; i--) begin
      for (int d = 0; d < 3; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end
      bcd = {bcd[10:0], v[i]};
    end
    return bcd;
  endfunction

endpackage

/* rtl/core/lcdseq_front.sv */
// front end: accepts command words, keeps the mode registers, builds jobs
// depends on lcdseq_pkg
module lcdseq_front #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  lcdseq_pkg::cmd_t     cmd,
  input  lcdseq_pkg::qstat_t   qstat,
  output logic                 push,
  output lcdseq_pkg::job_t     job
);
  import lcdseq_pkg::*;

  localparam logic [5:0] COL_MAX = 6'(COLUMNS);
  localparam logic [2:0] ROW_MAX = 3'(ROWS);

  logic [7:0] on_off_bits, on_off_bits_next;
  logic [7:0] shift_bits, shift_bits_next;
  logic [7:0] entry_bits, entry_bits_next;

  logic        accept;
  logic        has_job;
  logic [5:0]  col_clamp;
  logic [2:0]  row_clamp;
  logic [6:0]  col_adj;
  logic [7:0]  pos_byte;
  logic [11:0] bcd;

  assign cmd_stall = qstat.full;
  assign accept    = cmd_valid && !cmd_stall;
  assign push      = accept && has_job;

  // cursor position byte
  always_comb begin
    col_clamp = (cmd.column > COL_MAX) ? COL_MAX : cmd.column;
    row_clamp = (cmd.row > ROW_MAX) ? ROW_MAX : cmd.row;
    col_adj   = (row_clamp > 3'd2) ? ({1'b0, col_clamp} + {1'b0, COL_MAX})
                                   : {1'b0, col_clamp};
    pos_byte  = (row_clamp[0] ? POS_BASE_ODD : POS_BASE_EVEN) + {1'b0, col_adj};
  end

  assign bcd = to_bcd(cmd.value);

  // classify the command word and build the job
  always_comb begin
    has_job          = 1'b0;
    job              = '0;
    job.wait0        = WAIT_SHORT;
    on_off_bits_next = on_off_bits;
    shift_bits_next  = shift_bits;
    entry_bits_next  = entry_bits;
    case (op_t'(cmd.opcode))
      OP_INIT: begin
        has_job          = 1'b1;
        job.is_init      = 1'b1;
        on_off_bits_next = ON_OFF_RESET;
        shift_bits_next  = SHIFT_RESET;
        entry_bits_next  = ENTRY_RESET;
      end
      OP_RAW: begin
        has_job      = 1'b1;
        job.bytes[0] = cmd.value;
      end
      OP_CHAR: begin
        has_job      = 1'b1;
        job.rs0      = 1'b1;
        job.bytes[0] = cmd.value;
      end
      OP_POS: begin
        has_job      = 1'b1;
        job.bytes[0] = pos_byte;
      end
      OP_NUM: begin
        has_job       = 1'b1;
        job.nbytes_m1 = 2'd3;
        job.bytes[0]  = pos_byte;
        job.bytes[1]  = ASCII_ZERO + {4'b0, bcd[11:8]};
        job.bytes[2]  = ASCII_ZERO + {4'b0, bcd[7:4]};
        job.bytes[3]  = ASCII_ZERO + {4'b0, bcd[3:0]};
      end
      OP_CLEAR: begin
        has_job      = 1'b1;
        job.wait0    = WAIT_CLEAR;
        job.bytes[0] = CMD_CLEAR;
      end
      OP_MODE: begin
        has_job = 1'b1;
        case (sel_t'(cmd.flag_select))
          SEL_DISPLAY:     on_off_bits_next[2] = cmd.flag_value;
          SEL_CURSOR:      on_off_bits_next[1] = cmd.flag_value;
          SEL_BLINK:       on_off_bits_next[0] = cmd.flag_value;
          SEL_DISP_SHIFT:  shift_bits_next[3]  = cmd.flag_value;
          SEL_SHIFT_RIGHT: shift_bits_next[2]  = cmd.flag_value;
          SEL_ENTRY_RIGHT: entry_bits_next[1]  = cmd.flag_value;
          SEL_ENTRY_MOVE:  entry_bits_next[0]  = cmd.flag_value;
          default:         has_job             = 1'b0;
        endcase
        case (sel_t'(cmd.flag_select))
          SEL_DISPLAY, SEL_CURSOR, SEL_BLINK:
            job.bytes[0] = on_off_bits_next;
          SEL_DISP_SHIFT, SEL_SHIFT_RIGHT:
            job.bytes[0] = shift_bits_next;
          default:
            job.bytes[0] = entry_bits_next;
        endcase
      end
      default: has_job = 1'b0;
    endcase
  end

  // mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      on_off_bits <= ON_OFF_RESET;
      shift_bits  <= SHIFT_RESET;
      entry_bits  <= ENTRY_RESET;
    end else if (accept) begin
      on_off_bits <= on_off_bits_next;
      shift_bits  <= shift_bits_next;
      entry_bits  <= entry_bits_next;
    end
  end

endmodule

/* rtl/core/lcdseq_queue.sv */
// short job queue between front end and nibble sequencer
// depends on lcdseq_pkg
module lcdseq_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lcdseq_pkg::job_t     push_job,
  input  logic                 pop,
  output lcdseq_pkg::job_t     head,
  output lcdseq_pkg::qstat_t   qstat
);
  import lcdseq_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign head        = slots[rd_ptr];

  // job storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lcdseq_back.sv */
// back end: steps through the head job and drives the result register
// depends on lcdseq_pkg
module lcdseq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  lcdseq_pkg::job_t     head,
  input  lcdseq_pkg::qstat_t   qstat,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output lcdseq_pkg::res_t     res
);
  import lcdseq_pkg::*;

  logic [3:0] step;
  logic [1:0] byte_idx;
  logic [7:0] cur_byte;
  logic       load;
  res_t       gen;

  assign byte_idx = step[2:1];
  assign cur_byte = head.bytes[byte_idx];
  assign load     = !qstat.empty && (!res_valid || !res_stall);
  assign pop      = load && gen.last;

  // result for the current step of the head job
  always_comb begin
    if (head.is_init) begin
      gen      = init_res(step);
      gen.last = (step == INIT_LAST);
    end else begin
      gen            = '0;
      gen.strobe_res = 1'b1;
      gen.nibble     = step[0] ? cur_byte[3:0] : cur_byte[7:4];
      gen.reg_select = (byte_idx == 2'd0) ? head.rs0 : 1'b1;
      if (step[0]) gen.wait_code = (byte_idx == 2'd0) ? head.wait0 : WAIT_SHORT;
      else         gen.wait_code = WAIT_NONE;
      gen.last       = (step == {1'b0, head.nbytes_m1, 1'b1});
    end
  end

  // step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
      step      <= gen.last ? 4'd0 : step + 4'd1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (load) res <= gen;
  end

endmodule

/* rtl/core/char_lcd_nibble_command_sequencer.sv */
// character lcd nibble sequencer, top level: front end, job queue, back end
// a taken command is queued as a job; its nibble words come from the result register
// throughput: one nibble word per cycle while res_stall is low; a command expands to 2 to 12
// nibble words (12 for init, 8 for a number); an unused opcode or selector gives none
// reset: mode registers return to 0x0C / 0x14 / 0x06, queue empty, no result held
module char_lcd_nibble_command_sequencer #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  lcdseq_pkg::cmd_t   cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output lcdseq_pkg::res_t   res
);
  import lcdseq_pkg::*;

  logic   q_push;
  logic   q_pop;
  job_t   push_job;
  job_t   head;
  qstat_t qstat;

  // command decode and mode registers
  lcdseq_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .qstat     (qstat),
    .push      (q_push),
    .job       (push_job)
  );

  // job queue
  lcdseq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .qstat    (qstat)
  );

  // nibble sequencer
  lcdseq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // no job written into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !qstat.full)
    else $error("job pushed into full queue");

  // no job retired from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !qstat.empty)
    else $error("job popped from empty queue");

  // a job's words follow without a gap once its first word is taken
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res.last) |=> res_valid)
    else $error("gap inside a job's nibble words");

endmodule

/* sim/char_lcd_nibble_command_sequencer_tb.sv */
// self-checking bench for the character lcd nibble sequencer: command driver,
// result monitor and a behavioural predictor of the nibble word stream
// depends on lcdseq_pkg and char_lcd_nibble_command_sequencer
`timescale 1ns / 100ps

module char_lcd_nibble_command_sequencer_tb;
  import lcdseq_pkg::*;

  localparam int COLUMNS      = 20;
  localparam int ROWS         = 4;
  localparam int RANDOM_CMDS  = 400;
  localparam int MAX_IDLE     = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_MAX   = 10;

  // selector codes with no meaning in the block
  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam logic [2:0] SEL_UNUSED = 3'd7;

  // function set byte sent twice by the init sequence
  localparam logic [7:0] FUNC_SET_4BIT = 8'h2C;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;

  // mode bit masks within their registers
  localparam logic [7:0] MASK_DISPLAY     = 8'h04;
  localparam logic [7:0] MASK_CURSOR      = 8'h02;
  localparam logic [7:0] MASK_BLINK       = 8'h01;
  localparam logic [7:0] MASK_DISP_SHIFT  = 8'h08;
  localparam logic [7:0] MASK_SHIFT_RIGHT = 8'h04;
  localparam logic [7:0] MASK_ENTRY_RIGHT = 8'h02;
  localparam logic [7:0] MASK_ENTRY_MOVE  = 8'h01;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  cmd_t cmd_backlog[$];
  res_t lcd_words_due[$];

  // predictor copy of the mode registers
  logic [7:0] lcd_on_off;
  logic [7:0] lcd_shift;
  logic [7:0] lcd_entry;

  // words produced by one command before they are queued
  res_t cmd_words[16];
  int   cmd_word_cnt;

  int  fault_count = 0;
  int  cycle_count = 0;
  int  cmd_gap = 0;
  int  res_hold = 0;
  bit  cmd_calm = 1'b0;
  bit  res_calm = 1'b0;

  char_lcd_nibble_command_sequencer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one nibble word of the lcd bus
  task automatic lcd_word(input logic [3:0] nib, input logic rs, input logic pulse,
                          input logic [1:0] wt);
    res_t w;
    w.nibble     = nib;
    w.reg_select = rs;
    w.strobe_res = pulse;
    w.wait_code  = wt;
    w.last       = 1'b0;
    cmd_words[cmd_word_cnt] = w;
    cmd_word_cnt++;
  endtask

  // a byte goes out high nibble first, the wait sits on the low nibble
  task automatic lcd_byte(input logic [7:0] b, input logic rs, input logic [1:0] final_wait);
    lcd_word(b[7:4], rs, 1'b1, WAIT_NONE);
    lcd_word(b[3:0], rs, 1'b1, final_wait);
  endtask

  // display address for a row and column, clamped as the block does
  function automatic logic [7:0] ddram_addr(input logic [2:0] row, input logic [5:0] col);
    int r;
    int c;
    logic [7:0] base;
    r = (row > ROWS) ? ROWS : row;
    c = (col > COLUMNS) ? COLUMNS : col;
    if (r > 2) c += COLUMNS;
    base = (r % 2 == 1) ? POS_BASE_ODD : POS_BASE_EVEN;
    return 8'(base + c);
  endfunction

  task automatic reset_mode_regs();
    lcd_on_off = ON_OFF_RESET;
    lcd_shift  = SHIFT_RESET;
    lcd_entry  = ENTRY_RESET;
  endtask

  // expected nibble words for one accepted command
  task automatic predict_lcd_words(input cmd_t c);
    int v;
    logic [7:0] mask;
    logic [7:0] bits;
    cmd_word_cnt = 0;
    v = c.value;
    case (op_t'(c.opcode))
      OP_INIT: begin
        reset_mode_regs();
        lcd_word(4'h0, 1'b0, 1'b0, WAIT_POWERUP);
        lcd_word(WAKE_NIBBLE, 1'b0, 1'b1, WAIT_SHORT);
        lcd_byte(FUNC_SET_4BIT, 1'b0, WAIT_SHORT);
        lcd_byte(FUNC_SET_4BIT, 1'b0, WAIT_SHORT);
        lcd_byte(ON_OFF_RESET, 1'b0, WAIT_SHORT);
        lcd_byte(CMD_CLEAR, 1'b0, WAIT_CLEAR);
        lcd_byte(ENTRY_RESET, 1'b0, WAIT_SHORT);
      end
      OP_RAW:   lcd_byte(c.value, 1'b0, WAIT_SHORT);
      OP_CHAR:  lcd_byte(c.value, 1'b1, WAIT_SHORT);
      OP_POS:   lcd_byte(ddram_addr(c.row, c.column), 1'b0, WAIT_SHORT);
      OP_NUM: begin
        lcd_byte(ddram_addr(c.row, c.column), 1'b0, WAIT_SHORT);
        lcd_byte(ASCII_ZERO + 8'(v / 100), 1'b1, WAIT_SHORT);
        lcd_byte(ASCII_ZERO + 8'((v / 10) % 10), 1'b1, WAIT_SHORT);
        lcd_byte(ASCII_ZERO + 8'(v % 10), 1'b1, WAIT_SHORT);
      end
      OP_CLEAR: lcd_byte(CMD_CLEAR, 1'b0, WAIT_CLEAR);
      OP_MODE: begin
        // pick the bit, then update and send the register that owns it
        case (sel_t'(c.flag_select))
          SEL_DISPLAY:     mask = MASK_DISPLAY;
          SEL_CURSOR:      mask = MASK_CURSOR;
          SEL_BLINK:       mask = MASK_BLINK;
          SEL_DISP_SHIFT:  mask = MASK_DISP_SHIFT;
          SEL_SHIFT_RIGHT: mask = MASK_SHIFT_RIGHT;
          SEL_ENTRY_RIGHT: mask = MASK_ENTRY_RIGHT;
          SEL_ENTRY_MOVE:  mask = MASK_ENTRY_MOVE;
          default:         mask = '0;
        endcase
        case (sel_t'(c.flag_select))
          SEL_DISPLAY, SEL_CURSOR, SEL_BLINK: begin
            lcd_on_off = c.flag_value ? (lcd_on_off | mask) : (lcd_on_off & ~mask);
            lcd_byte(lcd_on_off, 1'b0, WAIT_SHORT);
          end
          SEL_DISP_SHIFT, SEL_SHIFT_RIGHT: begin
            lcd_shift = c.flag_value ? (lcd_shift | mask) : (lcd_shift & ~mask);
            lcd_byte(lcd_shift, 1'b0, WAIT_SHORT);
          end
          SEL_ENTRY_RIGHT, SEL_ENTRY_MOVE: begin
            bits = c.flag_value ? (lcd_entry | mask) : (lcd_entry & ~mask);
            lcd_entry = bits;
            lcd_byte(lcd_entry, 1'b0, WAIT_SHORT);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (cmd_word_cnt > 0) cmd_words[cmd_word_cnt - 1].last = 1'b1;
    for (int i = 0; i < cmd_word_cnt; i++) lcd_words_due.push_back(cmd_words[i]);
  endtask

  task automatic queue_cmd(input logic [2:0] op, input logic [2:0] row, input logic [5:0] col,
                           input logic [7:0] val, input logic [2:0] sel, input logic fv);
    cmd_t c;
    c.opcode      = op;
    c.row         = row;
    c.column      = col;
    c.value       = val;
    c.flag_select = sel;
    c.flag_value  = fv;
    cmd_backlog.push_back(c);
  endtask

  // command driver: holds a word until taken, then idles a drawn number of cycles
  always @(posedge clk) begin : cmd_driver
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_gap = 0;
      reset_mode_regs();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        predict_lcd_words(cmd);
        if ($urandom_range(0, 15) == 0) cmd_calm = !cmd_calm;
        cmd_gap = cmd_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_gap > 0) begin
          cmd_gap--;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cmd       <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each taken word with the oldest expected one
  always @(posedge clk) begin : res_monitor
    res_t due;
    if (rst) begin
      res_stall <= 1'b0;
      res_hold = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (lcd_words_due.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("%0t: unexpected word nibble=%h rs=%b strobe=%b wait=%0d last=%b",
                     $realtime, res.nibble, res.reg_select, res.strobe_res,
                     res.wait_code, res.last);
        end else begin
          due = lcd_words_due.pop_front();
          if (res.nibble !== due.nibble || res.reg_select !== due.reg_select ||
              res.strobe_res !== due.strobe_res || res.wait_code !== due.wait_code ||
              res.last !== due.last) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("%0t: mismatch exp %h/%b/%b/%0d/%b got %h/%b/%b/%0d/%b",
                       $realtime, due.nibble, due.reg_select, due.strobe_res,
                       due.wait_code, due.last, res.nibble, res.reg_select,
                       res.strobe_res, res.wait_code, res.last);
          end
        end
        if ($urandom_range(0, 15) == 0) res_calm = !res_calm;
        res_hold = res_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (res_hold > 0) begin
        res_hold--;
      end
      res_stall <= (res_hold != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    cmd_t c;
    int   useful;
    int   pick;

    // directed: extremes of the fields, every opcode, clamping and unused selectors
    queue_cmd(OP_INIT,  3'd0, 6'd0,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_RAW,   3'd0, 6'd0,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_RAW,   3'd7, 6'd63, 8'hFF, SEL_ENTRY_MOVE, 1'b1);
    queue_cmd(OP_CHAR,  3'd0, 6'd0,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_CHAR,  3'd0, 6'd0,  8'hFF, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_POS,   3'd0, 6'd0,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_POS,   3'd1, 6'd19, 8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_POS,   3'd2, 6'd20, 8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_POS,   3'd3, 6'd63, 8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_POS,   3'd4, 6'd5,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_POS,   3'd7, 6'd63, 8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_NUM,   3'd0, 6'd0,  8'd0,   SEL_DISPLAY, 1'b0);
    queue_cmd(OP_NUM,   3'd7, 6'd63, 8'd255, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_NUM,   3'd1, 6'd1,  8'd100, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_NUM,   3'd3, 6'd21, 8'd99,  SEL_DISPLAY, 1'b0);
    queue_cmd(OP_CLEAR, 3'd0, 6'd0,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_CURSOR, 1'b1);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_BLINK, 1'b1);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_DISP_SHIFT, 1'b1);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_SHIFT_RIGHT, 1'b0);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_ENTRY_RIGHT, 1'b0);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_ENTRY_MOVE, 1'b1);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_UNUSED, 1'b1);
    queue_cmd(OP_UNUSED, 3'd5, 6'd33, 8'hA5, SEL_BLINK, 1'b1);
    // init after mode changes must restore the registers
    queue_cmd(OP_INIT,  3'd0, 6'd0,  8'h00, SEL_DISPLAY, 1'b0);
    queue_cmd(OP_MODE,  3'd0, 6'd0,  8'h00, SEL_BLINK, 1'b0);

    // random commands, mostly meaningful ones with every field randomised
    useful = 0;
    while (useful < RANDOM_CMDS) begin
      c.row         = 3'($urandom);
      c.column      = 6'($urandom);
      c.value       = 8'($urandom);
      c.flag_value  = 1'($urandom);
      c.flag_select = 3'($urandom_range(SEL_ENTRY_MOVE, SEL_DISPLAY));
      pick = $urandom_range(0, 99);
      if (pick < 4)       c.opcode = OP_INIT;
      else if (pick < 18) c.opcode = OP_RAW;
      else if (pick < 36) c.opcode = OP_CHAR;
      else if (pick < 50) c.opcode = OP_POS;
      else if (pick < 64) c.opcode = OP_NUM;
      else if (pick < 70) c.opcode = OP_CLEAR;
      else if (pick < 97) c.opcode = OP_MODE;
      else                c.opcode = OP_UNUSED;
      if (c.opcode == OP_MODE && $urandom_range(0, 19) == 0) c.flag_select = SEL_UNUSED;
      if (!(c.opcode == OP_UNUSED || (c.opcode == OP_MODE && c.flag_select == SEL_UNUSED)))
        useful++;
      cmd_backlog.push_back(c);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // wait on the falling edge so the driver's updates have settled
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || lcd_words_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fault_count == 0 && lcd_words_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
